### rtl/core/bfbd_pkg.sv
`timescale 1ns / 1ps
// bfbd_pkg: shared types and constants of the beat flash brightness decay block
// no dependencies

package bfbd_pkg;

  localparam int unsigned LevelW  = 6;
  localparam int unsigned PeriodW = 12;
  localparam int unsigned TagW    = 7;
  localparam int unsigned ByteW   = 8;

  // command codes
  localparam logic [ByteW-1:0] CMD_BANG    = 8'd4;
  localparam logic [ByteW-1:0] CMD_BEAT    = 8'd5;
  localparam logic [ByteW-1:0] CMD_BANG_UP = 8'd6;
  localparam logic [ByteW-1:0] CMD_BRIGHT  = 8'd7;

  // item kinds
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_MSG  = 1'b1;

  localparam logic [TagW-1:0]    TAG_RESET     = 7'd42;
  localparam logic [LevelW-1:0]  LEVEL_RESET   = 6'd1;
  localparam logic [LevelW-1:0]  PEAK_RESET    = 6'd16;
  localparam logic [LevelW-1:0]  PEAK_MIN      = 6'd8;
  localparam logic [PeriodW-1:0] PERIOD_RESET  = 12'd1000;
  localparam logic [PeriodW-1:0] PERIOD_BANG   = 12'd2500;
  localparam logic [PeriodW-1:0] PERIOD_BANGUP = 12'd10;
  localparam logic [PeriodW-1:0] PERIOD_BEAT   = 12'd6;
  localparam logic [PeriodW-1:0] COUNT_MAX     = 12'd4095;

  typedef struct packed {
    logic             op;
    logic             is_sysex;
    logic [ByteW-1:0] tag_byte;
    logic [ByteW-1:0] what_code;
    logic [ByteW-1:0] value_byte;
  } item_t;

  typedef struct packed {
    logic [LevelW-1:0] brightness;
    logic              beat_pulse;
    logic              hold_active;
  } result_t;

endpackage

### rtl/core/bfbd_item_if.sv
`timescale 1ns / 1ps
// bfbd_item_if: input channel of the beat flash block, valid/ready with item payload
// no dependencies

interface bfbd_item_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic       is_sysex;
  logic [7:0] tag_byte;
  logic [7:0] what_code;
  logic [7:0] value_byte;

  modport source (
    output valid, op, is_sysex, tag_byte, what_code, value_byte,
    input  ready
  );
  modport sink (
    input  valid, op, is_sysex, tag_byte, what_code, value_byte,
    output ready
  );
endinterface

### rtl/core/bfbd_result_if.sv
`timescale 1ns / 1ps
// bfbd_result_if: output channel of the beat flash block, valid/ready with result payload
// no dependencies

interface bfbd_result_if;
  logic       valid;
  logic       ready;
  logic [5:0] brightness;
  logic       beat_pulse;
  logic       hold_active;

  modport source (
    output valid, brightness, beat_pulse, hold_active,
    input  ready
  );
  modport sink (
    input  valid, brightness, beat_pulse, hold_active,
    output ready
  );
endinterface

### rtl/core/bfbd_in_reg.sv
`timescale 1ns / 1ps
// bfbd_in_reg: input register stage, holds one accepted item until it is processed
// depends on bfbd_pkg and bfbd_item_if

module bfbd_in_reg
  import bfbd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  bfbd_item_if.sink   item,
  input  logic        take,
  output logic        held,
  output item_t       held_item
);

  logic  valid;
  item_t data;

  assign item.ready = !valid || take;
  assign held       = valid;
  assign held_item  = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (item.valid && item.ready) begin
      valid <= 1'b1;
    end else if (take) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      data.op         <= item.op;
      data.is_sysex   <= item.is_sysex;
      data.tag_byte   <= item.tag_byte;
      data.what_code  <= item.what_code;
      data.value_byte <= item.value_byte;
    end
  end

endmodule

### rtl/core/bfbd_env.sv
`timescale 1ns / 1ps
// bfbd_env: envelope state and the per-item update logic, plus the tag register
// depends on bfbd_pkg

module bfbd_env
  import bfbd_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            tag_we,
  input  logic [TagW-1:0] tag_wdata,
  input  logic            step,
  input  item_t           cur,
  output result_t         res
);

  logic [TagW-1:0]    sysex_tag;
  logic [LevelW-1:0]  level;
  logic [LevelW-1:0]  peak_level;
  logic [PeriodW-1:0] decay_period;
  logic [PeriodW-1:0] period_count;
  logic               started;
  logic               hold_flag;

  logic [LevelW-1:0]  level_next;
  logic [LevelW-1:0]  peak_level_next;
  logic [PeriodW-1:0] decay_period_next;
  logic [PeriodW-1:0] period_count_next;
  logic               started_next;
  logic               hold_flag_next;
  logic               pulse;

  logic [PeriodW-1:0] elapsed;
  logic [LevelW-1:0]  floor_level;
  logic [LevelW-1:0]  new_peak;
  logic               matched;

  always_comb begin
    elapsed     = (period_count == COUNT_MAX) ? COUNT_MAX : period_count + 1'b1;
    floor_level = peak_level >> 3;
    new_peak    = (cur.value_byte[7:2] < PEAK_MIN) ? PEAK_MIN : cur.value_byte[7:2];
    matched     = cur.is_sysex && (cur.tag_byte == {1'b0, sysex_tag});

    level_next        = level;
    peak_level_next   = peak_level;
    decay_period_next = decay_period;
    period_count_next = period_count;
    started_next      = started;
    hold_flag_next    = hold_flag;
    pulse             = 1'b0;

    if (cur.op == OP_TICK) begin
      if (!started || elapsed > decay_period) begin
        started_next      = 1'b1;
        period_count_next = '0;
        if (level > floor_level) begin
          level_next = level - 1'b1;
        end
      end else begin
        period_count_next = elapsed;
      end
    end else if (matched) begin
      case (cur.what_code)
        CMD_BANG: begin
          hold_flag_next    = 1'b1;
          decay_period_next = PERIOD_BANG;
          level_next        = peak_level;
          pulse             = 1'b1;
        end
        CMD_BANG_UP: begin
          hold_flag_next    = 1'b0;
          decay_period_next = PERIOD_BANGUP;
        end
        CMD_BEAT: begin
          if (!hold_flag) begin
            level_next        = peak_level;
            decay_period_next = PERIOD_BEAT;
            pulse             = 1'b1;
          end
        end
        CMD_BRIGHT: begin
          peak_level_next = new_peak;
          level_next      = new_peak >> 3;
        end
        default: begin
        end
      endcase
    end

    res.brightness  = level_next;
    res.beat_pulse  = pulse;
    res.hold_active = hold_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sysex_tag <= TAG_RESET;
    end else if (tag_we) begin
      sysex_tag <= tag_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level        <= LEVEL_RESET;
      peak_level   <= PEAK_RESET;
      decay_period <= PERIOD_RESET;
      period_count <= '0;
      started      <= 1'b0;
      hold_flag    <= 1'b0;
    end else if (step) begin
      level        <= level_next;
      peak_level   <= peak_level_next;
      decay_period <= decay_period_next;
      period_count <= period_count_next;
      started      <= started_next;
      hold_flag    <= hold_flag_next;
    end
  end

endmodule

### rtl/core/bfbd_out_reg.sv
`timescale 1ns / 1ps
// bfbd_out_reg: result register, holds one result until the sink takes it
// depends on bfbd_pkg and bfbd_result_if

module bfbd_out_reg
  import bfbd_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          load,
  input  result_t       res,
  output logic          space,
  bfbd_result_if.source result
);

  logic    valid;
  result_t data;

  assign space              = !valid || result.ready;
  assign result.valid       = valid;
  assign result.brightness  = data.brightness;
  assign result.beat_pulse  = data.beat_pulse;
  assign result.hold_active = data.hold_active;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (result.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= res;
    end
  end

endmodule

### rtl/core/beat_flash_brightness_decay.sv
`timescale 1ns / 1ps
// beat_flash_brightness_decay: top level of the LED flash-and-decay envelope
// depends on bfbd_pkg, bfbd_item_if, bfbd_result_if, bfbd_in_reg, bfbd_env, bfbd_out_reg

// LED brightness envelope. Each input transfer is either a one-millisecond
// tick or a control message; each one yields exactly one result transfer
// carrying the brightness level, a beat pulse flag and the hold state.
// Ticks decay the level by one step once the elapsed count passes the
// current decay period (the first tick after reset always counts as
// expired); a decay never takes the level below peak/8. Sysex messages
// whose tag matches sysex_tag trigger bang, bang up, beat or brightness
// commands. Throughput is one item per clock while the sink takes results:
// an item sits in the input register, one pass of update logic computes
// the new state and result, and the result register holds it for the
// sink. A result becomes valid once its item has passed from the input
// register through the update logic into the result register; a stalled
// sink holds the result and the input register, and input ready drops
// once both are full. Write sysex_tag only while no items are in flight.

module beat_flash_brightness_decay
  import bfbd_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            sysex_tag_we,
  input  logic [TagW-1:0] sysex_tag_wdata,
  bfbd_item_if.sink       item,
  bfbd_result_if.source   result
);

  logic    held;       // input register holds an item
  item_t   held_item;
  logic    space;      // result register can take a new result
  logic    fire;       // item processed this cycle
  result_t res;

  // process when there is an item and a free result slot
  assign fire = held && space;

  bfbd_in_reg u_in_reg (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .take      (fire),
    .held      (held),
    .held_item (held_item)
  );

  // state update and result computation in one pass
  bfbd_env u_env (
    .clk       (clk),
    .rst       (rst),
    .tag_we    (sysex_tag_we),
    .tag_wdata (sysex_tag_wdata),
    .step      (fire),
    .cur       (held_item),
    .res       (res)
  );

  bfbd_out_reg u_out_reg (
    .clk    (clk),
    .rst    (rst),
    .load   (fire),
    .res    (res),
    .space  (space),
    .result (result)
  );

endmodule

### bench/tb_beat_flash_brightness_decay.sv
`timescale 1ns / 1ps
// tb_beat_flash_brightness_decay: self-checking bench for the flash-and-decay envelope
// depends on bfbd_pkg, bfbd_item_if, bfbd_result_if and beat_flash_brightness_decay

module tb_beat_flash_brightness_decay;
  import bfbd_pkg::*;

  localparam int CYCLE_LIMIT   = 200_000;
  localparam int RANDOM_ITEMS  = 190;     // items with an effect per tag setting
  localparam int HOLD_OFF_AT   = 300;     // result count at which the sink stalls long
  localparam int HOLD_OFF_LEN  = 120;
  localparam int REPORT_LIMIT  = 10;

  // command codes the block has to ignore
  localparam logic [ByteW-1:0] CMD_IGNORED_LO   = 8'd0;
  localparam logic [ByteW-1:0] CMD_IGNORED_HI   = 8'd255;
  localparam logic [ByteW-1:0] CMD_IGNORED_NEXT = CMD_BRIGHT + 8'd1;

  typedef struct {
    item_t   it;
    bit      typed;    // want holds a hand-written result
    result_t want;
  } stim_row_t;

  logic clk;
  logic rst = 1'b1;
  logic            sysex_tag_we;
  logic [TagW-1:0] sysex_tag_wdata;

  bfbd_item_if   item_ch ();
  bfbd_result_if res_ch ();

  beat_flash_brightness_decay i_dut (
    .clk             (clk),
    .rst             (rst),
    .sysex_tag_we    (sysex_tag_we),
    .sysex_tag_wdata (sysex_tag_wdata),
    .item            (item_ch),
    .result          (res_ch)
  );

  // 20 ns clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // envelope shadow state, advanced once per accepted input transfer
  logic [TagW-1:0]    tag_shadow;
  logic [LevelW-1:0]  env_level;
  logic [LevelW-1:0]  env_peak;
  logic [PeriodW-1:0] env_period;
  logic [PeriodW-1:0] env_count;
  logic               env_started;
  logic               env_hold;

  result_t   expected_envelope[$];
  stim_row_t directed_rows[$];

  int sent_count;
  int got_count;
  int fail_count;
  int cycle_count;
  bit long_stall_done;

  // one step of the envelope: updates the shadow state, returns the result
  function automatic result_t step_envelope(input item_t it);
    result_t          r;
    logic [PeriodW:0] elapsed;
    logic [ByteW-1:0] new_peak;
    logic             pulse;
    pulse = 1'b0;
    if (it.op == OP_TICK) begin
      // elapsed time saturates, the very first tick always counts as expired
      elapsed = env_count + 1'b1;
      if (elapsed > COUNT_MAX) elapsed = COUNT_MAX;
      if (!env_started || elapsed > env_period) begin
        env_started = 1'b1;
        env_count   = '0;
        if (env_level > (env_peak >> 3)) env_level = env_level - 1'b1;
      end else begin
        env_count = elapsed[PeriodW-1:0];
      end
    end else if (it.is_sysex && it.tag_byte == {1'b0, tag_shadow}) begin
      // a tag byte with its top bit set can never match
      case (it.what_code)
        CMD_BANG: begin
          env_hold   = 1'b1;
          env_period = PERIOD_BANG;
          env_level  = env_peak;
          pulse      = 1'b1;
        end
        CMD_BANG_UP: begin
          env_hold   = 1'b0;
          env_period = PERIOD_BANGUP;
        end
        CMD_BEAT: begin
          if (!env_hold) begin
            env_level  = env_peak;
            env_period = PERIOD_BEAT;
            pulse      = 1'b1;
          end
        end
        CMD_BRIGHT: begin
          new_peak = it.value_byte >> 2;
          if (new_peak < PEAK_MIN) new_peak = PEAK_MIN;
          env_peak  = new_peak[LevelW-1:0];
          env_level = env_peak >> 3;
        end
        default: ;
      endcase
    end
    r.brightness  = env_level;
    r.beat_pulse  = pulse;
    r.hold_active = env_hold;
    return r;
  endfunction

  // idle cycles before the next transfer; some stretches run with no gaps
  function automatic int idle_draw(input int n);
    if ((n / 40) % 3 == 1) return 0;
    return $urandom_range(0, 5);
  endfunction

  // random item: mostly ticks and well-formed messages, some noise
  function automatic item_t draw_item();
    item_t it;
    int    pick;
    it.op         = OP_TICK;
    it.is_sysex   = 1'($urandom_range(0, 1));
    it.tag_byte   = ByteW'($urandom_range(0, 255));
    it.what_code  = ByteW'($urandom_range(0, 255));
    it.value_byte = ByteW'($urandom_range(0, 255));
    if ($urandom_range(0, 99) < 60) return it;
    it.op = OP_MSG;
    if ($urandom_range(0, 99) < 80) begin
      it.is_sysex = 1'b1;
      it.tag_byte = {1'b0, tag_shadow};
      pick = $urandom_range(0, 99);
      if (pick < 15)      it.what_code = CMD_BANG;
      else if (pick < 35) it.what_code = CMD_BANG_UP;
      else if (pick < 75) it.what_code = CMD_BEAT;
      else                it.what_code = CMD_BRIGHT;
    end else if ($urandom_range(0, 1)) begin
      // aliases the register in its low seven bits only
      it.tag_byte = {1'b1, tag_shadow};
    end
    return it;
  endfunction

  task automatic add_row(input logic op, input logic sx, input logic [ByteW-1:0] tag,
                         input logic [ByteW-1:0] what, input logic [ByteW-1:0] val,
                         input bit typed, input logic [LevelW-1:0] lvl,
                         input logic pulse, input logic hold);
    stim_row_t row;
    row.it    = '{op: op, is_sysex: sx, tag_byte: tag, what_code: what, value_byte: val};
    row.typed = typed;
    row.want  = '{brightness: lvl, beat_pulse: pulse, hold_active: hold};
    directed_rows.push_back(row);
  endtask

  // offers one item and waits for its transfer; valid stays high afterwards
  task automatic send_item(input item_t it, input bit typed, input result_t want);
    int      gap;
    result_t pred;
    gap = idle_draw(sent_count);
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_ch.valid      <= 1'b1;
    item_ch.op         <= it.op;
    item_ch.is_sysex   <= it.is_sysex;
    item_ch.tag_byte   <= it.tag_byte;
    item_ch.what_code  <= it.what_code;
    item_ch.value_byte <= it.value_byte;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    // the shadow state always advances, even where the row carries its own result
    pred = step_envelope(it);
    expected_envelope.push_back(typed ? want : pred);
    sent_count++;
  endtask

  // stop offering, let every result drain, then wait out the pipeline
  task automatic settle();
    item_ch.valid <= 1'b0;
    while (expected_envelope.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_tag(input logic [TagW-1:0] v);
    sysex_tag_we    <= 1'b1;
    sysex_tag_wdata <= v;
    @(posedge clk);
    sysex_tag_we <= 1'b0;
    tag_shadow = v;
  endtask

  // source side: directed rows, then random phases under several tag settings
  initial begin : source_side
    item_t      it;
    int         effective;
    logic [TagW-1:0] phase_tag [4];
    tag_shadow  = TAG_RESET;
    env_level   = LEVEL_RESET;
    env_peak    = PEAK_RESET;
    env_period  = PERIOD_RESET;
    env_count   = '0;
    env_started = 1'b0;
    env_hold    = 1'b0;
    item_ch.valid      <= 1'b0;
    item_ch.op         <= OP_TICK;
    item_ch.is_sysex   <= 1'b0;
    item_ch.tag_byte   <= '0;
    item_ch.what_code  <= '0;
    item_ch.value_byte <= '0;
    sysex_tag_we       <= 1'b0;
    sysex_tag_wdata    <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // first tick counts as expired, but level 1 already sits below the floor of peak/8
    add_row(OP_TICK, 1'b0, 8'h00, CMD_IGNORED_LO, 8'h00, 1, 6'd1, 1'b0, 1'b0);
    // brightness extremes: zero is raised to the minimum peak, 255 gives peak 63
    add_row(OP_MSG, 1'b1, TAG_RESET, CMD_BRIGHT, 8'h00, 1, 6'd1, 1'b0, 1'b0);
    add_row(OP_MSG, 1'b1, TAG_RESET, CMD_BRIGHT, 8'hff, 1, 6'd7, 1'b0, 1'b0);
    add_row(OP_MSG, 1'b1, TAG_RESET, CMD_BEAT, 8'h00, 1, 6'd63, 1'b1, 1'b0);
    // short beat period: six ticks wait, the seventh decays
    repeat (7) add_row(OP_TICK, 1'b0, 8'h00, CMD_IGNORED_LO, 8'h00, 0, '0, 1'b0, 1'b0);
    add_row(OP_MSG, 1'b1, TAG_RESET, CMD_BANG, 8'h00, 1, 6'd63, 1'b1, 1'b1);
    // beat while held does nothing
    add_row(OP_MSG, 1'b1, TAG_RESET, CMD_BEAT, 8'h00, 1, 6'd63, 1'b0, 1'b1);
    add_row(OP_MSG, 1'b1, TAG_RESET, CMD_BANG_UP, 8'h00, 1, 6'd63, 1'b0, 1'b0);
    // ignored messages: not sysex, tag with top bit set, wrong tag, unknown codes
    add_row(OP_MSG, 1'b0, TAG_RESET, CMD_BANG, 8'h00, 1, 6'd63, 1'b0, 1'b0);
    add_row(OP_MSG, 1'b1, {1'b1, TAG_RESET}, CMD_BANG, 8'h00, 1, 6'd63, 1'b0, 1'b0);
    add_row(OP_MSG, 1'b1, TAG_RESET + 8'd1, CMD_BANG, 8'h00, 1, 6'd63, 1'b0, 1'b0);
    add_row(OP_MSG, 1'b1, TAG_RESET, CMD_IGNORED_LO, 8'hff, 1, 6'd63, 1'b0, 1'b0);
    add_row(OP_MSG, 1'b1, TAG_RESET, CMD_IGNORED_HI, 8'hff, 1, 6'd63, 1'b0, 1'b0);
    add_row(OP_MSG, 1'b1, TAG_RESET, CMD_IGNORED_NEXT, 8'h00, 1, 6'd63, 1'b0, 1'b0);
    // brightness right around the minimum peak
    add_row(OP_MSG, 1'b1, TAG_RESET, CMD_BRIGHT, 8'd31, 1, 6'd1, 1'b0, 1'b0);
    add_row(OP_MSG, 1'b1, TAG_RESET, CMD_BRIGHT, 8'd35, 0, '0, 1'b0, 1'b0);
    add_row(OP_MSG, 1'b1, TAG_RESET, CMD_BRIGHT, 8'd64, 0, '0, 1'b0, 1'b0);
    // a tick ignores every other field
    add_row(OP_TICK, 1'b1, 8'hff, CMD_IGNORED_HI, 8'hff, 0, '0, 1'b0, 1'b0);
    add_row(OP_MSG, 1'b1, TAG_RESET, CMD_BEAT, 8'hff, 0, '0, 1'b0, 1'b0);

    foreach (directed_rows[i])
      send_item(directed_rows[i].it, directed_rows[i].typed, directed_rows[i].want);

    // tag register extremes, then two random settings
    phase_tag[0] = '0;
    phase_tag[1] = '1;
    phase_tag[2] = TagW'($urandom_range(1, 126));
    phase_tag[3] = TagW'($urandom_range(0, 127));
    for (int ph = 0; ph < 4; ph++) begin
      settle();
      write_tag(phase_tag[ph]);
      effective = 0;
      while (effective < RANDOM_ITEMS) begin
        it = draw_item();
        // only ticks and accepted commands count toward the phase length
        if (it.op == OP_TICK ||
            (it.is_sysex && it.tag_byte == {1'b0, tag_shadow} &&
             it.what_code >= CMD_BANG && it.what_code <= CMD_BRIGHT))
          effective++;
        send_item(it, 1'b0, '0);
      end
    end

    // drain and let the pipeline go quiet before the verdict
    settle();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && expected_envelope.size() == 0)
      $display("[beat_flash_brightness_decay] OK");
    else
      $display("[beat_flash_brightness_decay] ERROR");
    $finish;
  end

  // sink side: random stalls, one long hold-off so the block backs up its input
  initial begin : sink_side
    int      stall;
    result_t got;
    result_t want;
    res_ch.ready <= 1'b0;
    wait (rst == 1'b0);
    @(posedge clk);
    forever begin
      stall = idle_draw(got_count + 17);
      if (got_count == HOLD_OFF_AT && !long_stall_done) begin
        stall = HOLD_OFF_LEN;
        long_stall_done = 1'b1;
      end
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      @(posedge clk);
      while (!res_ch.valid) @(posedge clk);
      got.brightness  = res_ch.brightness;
      got.beat_pulse  = res_ch.beat_pulse;
      got.hold_active = res_ch.hold_active;
      got_count++;
      if (expected_envelope.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
          $display("result %0d with none pending: level %0d pulse %0b hold %0b",
                   got_count, got.brightness, got.beat_pulse, got.hold_active);
      end else begin
        want = expected_envelope.pop_front();
        if (got.brightness !== want.brightness || got.beat_pulse !== want.beat_pulse ||
            got.hold_active !== want.hold_active) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT)
            $display("result %0d mismatch: level %0d/%0d pulse %0b/%0b hold %0b/%0b (exp/got)",
                     got_count, want.brightness, got.brightness, want.beat_pulse,
                     got.beat_pulse, want.hold_active, got.hold_active);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[beat_flash_brightness_decay] ERROR");
      $finish;
    end
  end

endmodule
